### rtl/pwrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwrm_pkg
// shared types and constants of the peak and windowed rms meter
// ----------------------------------------------------------------------------
package pwrm_pkg;

  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_block;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] peak_level;
    logic [SAMPLE_BITS-1:0] rms_level;
  } out_item_t;

  // width of the exact sum of squares over a window of the given length
  function automatic int unsigned sum_width(int unsigned window);
    return 2 * (SAMPLE_BITS - 1) + $clog2(window) + 1;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] magnitude(logic [SAMPLE_BITS-1:0] raw);
    logic [SAMPLE_BITS-1:0] neg;
    neg = ~raw + 1'b1;
    return raw[SAMPLE_BITS-1] ? neg : raw;
  endfunction

endpackage

### rtl/pwrm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwrm_queue
// short fifo of block reports between the front and the back part
// ----------------------------------------------------------------------------
module pwrm_queue #(
  parameter int unsigned DEPTH  = 4,
  parameter int unsigned DATA_W = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [DATA_W-1:0]            data_i,
  input  logic                         pop_i,
  output logic                         valid_o,
  output logic [DATA_W-1:0]            data_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem[rd_ptr_q];
  assign count_o = cnt_q;

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q < CNT_W'(DEPTH)))
    else $error("report queue overflow");

endmodule

### rtl/pwrm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwrm_front
// sample ring, running sum of squares and peak hold; hands block reports on
// ----------------------------------------------------------------------------
module pwrm_front import pwrm_pkg::*; #(
  parameter int unsigned WINDOW = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,
  input  logic                              push_i,
  input  in_item_t                          item_i,
  output logic                              full_o,
  input  logic [QCNT_W-1:0]                 q_count_i,
  output logic                              q_push_o,
  output logic [SAMPLE_BITS-1:0]            q_peak_o,
  output logic [sum_width(WINDOW)-1:0]      q_sum_o
);

  localparam int unsigned IDX_W = $clog2(WINDOW);
  localparam int unsigned SUM_W = sum_width(WINDOW);
  localparam int unsigned SQ_W  = 2 * SAMPLE_BITS;
  localparam int unsigned PND_W = QCNT_W + 1;

  logic                   susp_q;
  logic                   clr_q;
  logic [IDX_W-1:0]       clr_idx_q;
  logic [IDX_W-1:0]       slot_q;
  logic [SAMPLE_BITS-1:0] ring [WINDOW];
  logic [SAMPLE_BITS-1:0] rd_q;

  logic                   s1_v_q, s1_eob_q;
  logic [SAMPLE_BITS-1:0] s1_smp_q;
  logic                   s2_v_q, s2_eob_q;
  logic [SAMPLE_BITS-1:0] s2_mag_q;
  logic [SQ_W-1:0]        s2_sqn_q, s2_sqo_q;

  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] peak_q, peak_d;

  logic                   take;
  logic [PND_W-1:0]       pending;
  logic [IDX_W-1:0]       mem_addr;
  logic                   mem_we;
  logic [SAMPLE_BITS-1:0] mem_wd;
  logic [SAMPLE_BITS-1:0] mag_new, mag_old;

  // reports that may still land in the queue
  assign pending = PND_W'(q_count_i) + PND_W'(s1_v_q & s1_eob_q)
                 + PND_W'(s2_v_q & s2_eob_q);
  assign full_o  = clr_q | (pending >= PND_W'(QUEUE_DEPTH));
  assign take    = push_i & ~full_o & ~susp_q;

  assign mem_addr = clr_q ? clr_idx_q : slot_q;
  assign mem_we   = clr_q | take;
  assign mem_wd   = clr_q ? '0 : item_i.sample;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring[mem_addr] <= mem_wd;
    end
    if (take) begin
      rd_q <= ring[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      susp_q    <= 1'b0;
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
      slot_q    <= '0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      sum_q     <= '0;
      peak_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        susp_q <= cfg_wdata_i;
      end
      if (clr_q) begin
        if (clr_idx_q == IDX_W'(WINDOW - 1)) begin
          clr_q <= 1'b0;
        end
        clr_idx_q <= clr_idx_q + 1'b1;
      end
      if (take) begin
        slot_q <= (slot_q == IDX_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
      end
      s1_v_q <= take;
      s2_v_q <= s1_v_q;
      if (s2_v_q) begin
        sum_q  <= sum_d;
        peak_q <= peak_d;
      end
    end
  end

  assign mag_new = magnitude(s1_smp_q);
  assign mag_old = magnitude(rd_q);

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_eob_q <= item_i.end_of_block;
      s1_smp_q <= item_i.sample;
    end
    if (s1_v_q) begin
      s2_eob_q <= s1_eob_q;
      s2_mag_q <= mag_new;
      s2_sqn_q <= mag_new * mag_new;
      s2_sqo_q <= mag_old * mag_old;
    end
  end

  assign sum_d  = sum_q + SUM_W'(s2_sqn_q) - SUM_W'(s2_sqo_q);
  assign peak_d = (s2_mag_q > peak_q) ? s2_mag_q : peak_q;

  assign q_push_o = s2_v_q & s2_eob_q;
  assign q_peak_o = peak_d;
  assign q_sum_o  = sum_d;

  a_no_take_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !take)
    else $error("sample taken during ring clear");

  a_peak_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (peak_q >= $past(peak_q)))
    else $error("peak hold decayed");

endmodule

### rtl/pwrm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwrm_back
// floor square root of the mean square, one root bit a cycle
// ----------------------------------------------------------------------------
module pwrm_back import pwrm_pkg::*; #(
  parameter int unsigned WINDOW = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  logic [SAMPLE_BITS-1:0]        q_peak_i,
  input  logic [sum_width(WINDOW)-1:0]  q_sum_i,
  input  logic                          pop_i,
  output logic                          empty_o,
  output out_item_t                     item_o
);

  localparam int unsigned SUM_W = sum_width(WINDOW);
  localparam int unsigned T_W   = SUM_W + 1;
  localparam int unsigned CNT_W = $clog2(SAMPLE_BITS);
  localparam logic [T_W-1:0] BIT_INIT = T_W'(WINDOW) << (2 * (SAMPLE_BITS - 1));

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQRT = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]             state_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   out_v_q;
  out_item_t              out_q;

  logic [SAMPLE_BITS-1:0] pk_q;
  logic [T_W-1:0]         rem_q, res_q, bit_q, trial;
  logic                   rbit;
  logic [SAMPLE_BITS-1:0] root_q;
  logic                   free;
  logic                   sqrt_last;

  // digit-by-digit square root with the window folded into the trial values
  assign trial = res_q + bit_q;
  assign rbit  = (rem_q >= trial);

  assign free      = ~out_v_q | pop_i;
  assign sqrt_last = (cnt_q == CNT_W'(SAMPLE_BITS - 1));
  assign q_pop_o   = (state_q == ST_IDLE) & q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            state_q <= ST_SQRT;
            cnt_q   <= '0;
          end
        end
        ST_SQRT: begin
          if (sqrt_last) begin
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DONE: begin
          if (free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if ((state_q == ST_DONE) && free) begin
        out_v_q <= 1'b1;
      end else if (pop_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          rem_q  <= T_W'(q_sum_i);
          res_q  <= '0;
          bit_q  <= BIT_INIT;
          root_q <= '0;
          pk_q   <= q_peak_i;
        end
      end
      ST_SQRT: begin
        rem_q  <= rbit ? (rem_q - trial) : rem_q;
        res_q  <= rbit ? ((res_q >> 1) + bit_q) : (res_q >> 1);
        bit_q  <= bit_q >> 2;
        root_q <= {root_q[SAMPLE_BITS-2:0], rbit};
      end
      ST_DONE: begin
        if (free) begin
          out_q.peak_level <= pk_q;
          out_q.rms_level  <= root_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign empty_o = ~out_v_q;
  assign item_o  = out_q;

  a_start_on_report : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && q_valid_i) |=> (state_q == ST_SQRT))
    else $error("report not taken by idle back part");

  a_result_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && free) |=> (out_v_q && state_q == ST_IDLE))
    else $error("finished result not loaded");

endmodule

### rtl/peak_and_windowed_rms_meter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peak_and_windowed_rms_meter_unit
// peak hold and moving-window rms level of a signed audio sample stream
// ----------------------------------------------------------------------------
// Samples enter through a queue-like port: push with full, one transfer per
// cycle while full is low. Each sample updates the peak hold and a ring of
// the last WINDOW samples with an exact running sum of squares; a sample
// flagged end_of_block also posts a report. Reports appear on out_item_o
// while empty is low and leave on pop.
// The front part takes one sample per cycle while full is low and posts a
// report into a four-entry queue through its s1 and s2 registers after the
// end-of-block sample is taken. The back part turns one report at a time
// into a result with its bit-serial square root; end-of-block samples that
// come faster than the back part finishes reports fill the queue and raise
// full.
// A stalled output holds its result; the back part waits with the next one
// finished, and the front keeps taking samples until queued and in-flight
// reports fill the queue.
// After reset the ring is cleared, one entry a cycle, with full held high
// throughout. cfg_we_i with cfg_wdata_i sets suspend; while suspended,
// samples are taken and dropped. Write it only while the block is idle.
// ----------------------------------------------------------------------------
module peak_and_windowed_rms_meter_unit import pwrm_pkg::*; #(
  parameter int unsigned WINDOW = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  localparam int unsigned SUM_W  = sum_width(WINDOW);
  localparam int unsigned DATA_W = SAMPLE_BITS + SUM_W;

  logic                   q_push, q_valid, q_pop;
  logic [SAMPLE_BITS-1:0] f_peak, b_peak;
  logic [SUM_W-1:0]       f_sum, b_sum;
  logic [QCNT_W-1:0]      q_count;

  pwrm_front #(.WINDOW(WINDOW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .item_i      (in_item_i),
    .full_o      (full),
    .q_count_i   (q_count),
    .q_push_o    (q_push),
    .q_peak_o    (f_peak),
    .q_sum_o     (f_sum)
  );

  pwrm_queue #(.DEPTH(QUEUE_DEPTH), .DATA_W(DATA_W)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({f_peak, f_sum}),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  ({b_peak, b_sum}),
    .count_o (q_count)
  );

  pwrm_back #(.WINDOW(WINDOW)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .q_peak_i  (b_peak),
    .q_sum_i   (b_sum),
    .pop_i     (pop),
    .empty_o   (empty),
    .item_o    (out_item_o)
  );

endmodule

### test/tb_peak_and_windowed_rms_meter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_peak_and_windowed_rms_meter_unit
// self-checking bench for the peak hold and moving-window rms meter
// ----------------------------------------------------------------------------
// Samples go in through the push/full port. Each unsuspended sample updates
// a local copy of the peak hold, the sample window and its sum of squares,
// and each such end-of-block sample queues the expected peak and rms levels.
// Reports are popped with random stalls and compared field by field in order.
// The run covers the unfilled window, the extreme samples, a full-scale
// window, suspension and random streams under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_peak_and_windowed_rms_meter_unit;
  import pwrm_pkg::*;

  localparam int unsigned WINDOW       = 1024;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam logic        SUSPEND_ON   = 1'b1;
  localparam logic        SUSPEND_OFF  = 1'b0;

  localparam logic signed [SAMPLE_BITS-1:0] FULL_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] FULL_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic      cfg_wdata_i = 1'b0;
  logic      push        = 1'b0;
  logic      pop         = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      full;
  logic      empty;
  out_item_t out_item_o;

  // local copy of the meter state
  logic [SAMPLE_BITS-1:0] recent_samples [WINDOW];
  int unsigned            write_slot;
  logic [63:0]            square_sum;
  logic [SAMPLE_BITS-1:0] held_peak;
  logic                   meter_suspended;

  out_item_t   expected_levels [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned pop_stall_pct  = 0;

  peak_and_windowed_rms_meter_unit #(
    .WINDOW(WINDOW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [63:0] abs_wide(logic signed [SAMPLE_BITS-1:0] s);
    logic signed [63:0] v;
    v = s;
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] floor_root(logic [63:0] x);
    logic [SAMPLE_BITS:0] r;
    logic [SAMPLE_BITS:0] trial;
    r = '0;
    for (int i = SAMPLE_BITS; i >= 0; i--) begin
      trial    = r;
      trial[i] = 1'b1;
      if (trial * trial <= x) r = trial;
    end
    return r[SAMPLE_BITS-1:0];
  endfunction

  task automatic clear_meter_model();
    foreach (recent_samples[i]) recent_samples[i] = '0;
    write_slot      = 0;
    square_sum      = '0;
    held_peak       = '0;
    meter_suspended = SUSPEND_OFF;
  endtask

  task automatic predict_levels(in_item_t item);
    logic [63:0] new_mag;
    logic [63:0] old_mag;
    out_item_t   lv;
    if (meter_suspended) return;
    new_mag = abs_wide(item.sample);
    old_mag = abs_wide(recent_samples[write_slot]);
    if (new_mag > held_peak) held_peak = new_mag[SAMPLE_BITS-1:0];
    square_sum = square_sum - old_mag * old_mag + new_mag * new_mag;
    recent_samples[write_slot] = item.sample;
    write_slot = (write_slot + 1) % WINDOW;
    if (item.end_of_block) begin
      lv.peak_level = held_peak;
      lv.rms_level  = floor_root(square_sum / WINDOW);
      expected_levels.push_back(lv);
    end
  endtask

  // receiver side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= pop_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_levels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected report: peak %0d rms %0d",
                   out_item_o.peak_level, out_item_o.rms_level);
      end else begin
        want = expected_levels.pop_front();
        if (out_item_o.peak_level !== want.peak_level) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("peak_level mismatch: expected %0d actual %0d",
                     want.peak_level, out_item_o.peak_level);
        end
        if (out_item_o.rms_level !== want.rms_level) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("rms_level mismatch: expected %0d actual %0d",
                     want.rms_level, out_item_o.rms_level);
        end
      end
    end
  end

  // sender side, returns right after the accepting edge
  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] s, logic eob);
    in_item_t item;
    item.sample       = s;
    item.end_of_block = eob;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= item;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_levels(item);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_suspend(logic value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    meter_suspended = value;
  endtask

  // magnitude at most 2^mag_bits, with some full-scale and near-zero values
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(int unsigned mag_bits);
    int          r;
    int unsigned kind;
    r    = $urandom();
    kind = $urandom_range(0, 9);
    if (kind == 0 && mag_bits >= SAMPLE_BITS - 1)
      return $urandom_range(0, 1) ? FULL_POS : FULL_NEG;
    if (kind <= 2) return SAMPLE_BITS'(r >>> 27);
    return SAMPLE_BITS'(r >>> (31 - mag_bits));
  endfunction

  task automatic test_reset_and_setup();
    clear_meter_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    write_suspend(SUSPEND_OFF);
  endtask

  // window mostly zero still
  task automatic test_unfilled_window();
    send_sample('0, 1'b1);
    send_sample(SAMPLE_BITS'(1), 1'b1);
    send_sample(SAMPLE_BITS'(-1), 1'b0);
    send_sample(SAMPLE_BITS'(-2), 1'b1);
    send_sample(SAMPLE_BITS'(1000), 1'b0);
    send_sample(SAMPLE_BITS'(-4096), 1'b1);
    send_sample(SAMPLE_BITS'(31), 1'b1);
  endtask

  task automatic test_extreme_samples();
    send_sample(FULL_POS, 1'b1);
    send_sample(FULL_NEG, 1'b1);
    send_sample(FULL_POS, 1'b0);
    send_sample(FULL_NEG + 1'b1, 1'b1);
    send_sample(SAMPLE_BITS'(12345), 1'b0);
    send_sample(SAMPLE_BITS'(-12345), 1'b1);
    send_sample('0, 1'b1);
  endtask

  task automatic test_suspended_stream(int unsigned count);
    wait_idle();
    write_suspend(SUSPEND_ON);
    for (int i = 0; i < count; i++)
      send_sample(pick_sample(SAMPLE_BITS - 1), 1'($urandom_range(0, 1)));
    send_sample(FULL_NEG, 1'b1);
    wait_idle();
    write_suspend(SUSPEND_OFF);
    send_sample(SAMPLE_BITS'(7), 1'b1);
  endtask

  task automatic test_full_scale_window();
    for (int i = 0; i < WINDOW; i++)
      send_sample(FULL_NEG, (i == WINDOW - 1));
    send_sample(FULL_POS, 1'b1);
    send_sample('0, 1'b1);
  endtask

  task automatic test_random_stream(int unsigned count, int unsigned idle_pct,
                                    int unsigned stall_pct, int unsigned mag_bits);
    wait_idle();
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    for (int i = 0; i < count; i++)
      send_sample(pick_sample(mag_bits), ($urandom_range(0, 7) == 0));
  endtask

  initial begin
    test_reset_and_setup();
    test_unfilled_window();
    test_random_stream(75, 0, 0, 10);
    test_random_stream(75, 82, 0, 18);
    test_suspended_stream(12);
    test_extreme_samples();
    test_random_stream(75, 0, 82, SAMPLE_BITS - 1);
    send_idle_pct = 0;
    pop_stall_pct = 0;
    test_full_scale_window();
    test_random_stream(75, 24, 24, SAMPLE_BITS - 1);
    wait_idle();
    if (mismatch_count == 0 && expected_levels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
